/* sv/jci_pkg.sv */
// ----------------------------------------------------------------------------
// jci_pkg
// Shared types and constants of the joint command interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package jci_pkg;

   localparam int DEFAULT_NUM_JOINTS = 32;
   localparam int NUM_WORDS          = 13;
   localparam int QUEUE_DEPTH        = 2;

   // item kinds
   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   // table word selects
   localparam logic [3:0] SEL_Q_START   = 4'd0;
   localparam logic [3:0] SEL_Q_DELTA   = 4'd1;
   localparam logic [3:0] SEL_DQ_START  = 4'd2;
   localparam logic [3:0] SEL_DQ_DELTA  = 4'd3;
   localparam logic [3:0] SEL_KP_START  = 4'd4;
   localparam logic [3:0] SEL_KP_DELTA  = 4'd5;
   localparam logic [3:0] SEL_KD_START  = 4'd6;
   localparam logic [3:0] SEL_KD_DELTA  = 4'd7;
   localparam logic [3:0] SEL_Q_MIN     = 4'd8;
   localparam logic [3:0] SEL_Q_MAX     = 4'd9;
   localparam logic [3:0] SEL_DQ_LIM    = 4'd10;
   localparam logic [3:0] SEL_TAU_LIM   = 4'd11;
   localparam logic [3:0] SEL_GROUP     = 4'd12;

   // configuration register indexes
   localparam logic [2:0] CSR_LOWER_KP_MIN = 3'd0;
   localparam logic [2:0] CSR_LOWER_KP_MAX = 3'd1;
   localparam logic [2:0] CSR_LOWER_KD_MIN = 3'd2;
   localparam logic [2:0] CSR_LOWER_KD_MAX = 3'd3;
   localparam logic [2:0] CSR_UPPER_KP_MIN = 3'd4;
   localparam logic [2:0] CSR_UPPER_KP_MAX = 3'd5;
   localparam logic [2:0] CSR_UPPER_KD_MIN = 3'd6;
   localparam logic [2:0] CSR_UPPER_KD_MAX = 3'd7;

   localparam logic [16:0] PHASE_ONE = 17'd65536;
   localparam logic [30:0] GAIN_MAX  = 31'h7FFF_FFFF;
   localparam logic [23:0] X_CAP     = 24'h80_0000;

   typedef struct packed {
      logic              req_type;
      logic [4:0]        joint_index;
      logic [3:0]        param_select;
      logic signed [31:0] param_value;
      logic [16:0]       phase;
      logic signed [31:0] meas_q;
      logic signed [31:0] meas_dq;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]         out_joint;
      logic signed [31:0] q_cmd;
      logic signed [31:0] dq_cmd;
      logic [30:0]        kp_cmd;
      logic [30:0]        kd_cmd;
      logic               motor_mode;
      logic               torque_scaled;
      logic               write_ack;
   } rsp_payload_type;

   typedef struct packed {
      logic [30:0] lower_kp_min;
      logic [30:0] lower_kp_max;
      logic [30:0] lower_kd_min;
      logic [30:0] lower_kd_max;
      logic [30:0] upper_kp_min;
      logic [30:0] upper_kp_max;
      logic [30:0] upper_kd_min;
      logic [30:0] upper_kd_max;
   } gain_cfg_type;

   typedef struct packed {
      logic                        is_write;
      logic                        bad_joint;
      logic [4:0]                  joint;
      logic [16:0]                 phase;
      logic signed [31:0]          meas_q;
      logic signed [31:0]          meas_dq;
      logic [NUM_WORDS-1:0][31:0]  words;
   } job_type;

endpackage

`default_nettype wire

/* sv/jci_ram.sv */
// ----------------------------------------------------------------------------
// jci_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/jci_front.sv */
// ----------------------------------------------------------------------------
// jci_front
// Accept items, store table words, fetch a joint's words for compute items.
// ----------------------------------------------------------------------------
`default_nettype none

module jci_front #(
   parameter int NUM_JOINTS = jci_pkg::DEFAULT_NUM_JOINTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire jci_pkg::req_payload_type req_item,
   output logic                          push_valid,
   output jci_pkg::job_type              push_job,
   input  wire logic                     push_ready
);
   import jci_pkg::*;

   localparam int         AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam logic [6:0] NJ = 7'(NUM_JOINTS);

   logic                       accept;
   logic                       joint_ok;
   logic [6:0]                 joint_ext;
   logic [AW-1:0]              addr;
   logic [NUM_WORDS-1:0][31:0] rd_words;

   logic               st_valid_ff, st_valid_in;
   logic               st_write_ff;
   logic               st_bad_ff;
   logic [4:0]         st_joint_ff;
   logic [16:0]        st_phase_ff, st_phase_in;
   logic signed [31:0] st_meas_q_ff;
   logic signed [31:0] st_meas_dq_ff;

   assign joint_ext = {2'b00, req_item.joint_index};
   assign joint_ok  = joint_ext < NJ;
   assign addr      = joint_ext[AW-1:0];
   assign req_ready = !st_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   generate
      for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
         jci_ram #(
            .WIDTH (32),
            .DEPTH (NUM_JOINTS)
         ) u_word (
            .clock   (clock),
            .wr_en   (accept && (req_item.req_type == REQ_WRITE) && joint_ok &&
                      (req_item.param_select == 4'(w))),
            .wr_addr (addr),
            .wr_data (req_item.param_value),
            .rd_en   (accept && (req_item.req_type == REQ_COMPUTE)),
            .rd_addr (addr),
            .rd_data (rd_words[w])
         );
      end
   endgenerate

   always_comb begin
      st_phase_in = (req_item.phase > PHASE_ONE) ? PHASE_ONE : req_item.phase;
      st_valid_in = st_valid_ff;
      if (push_ready) begin
         st_valid_in = 1'b0;
      end
      if (accept) begin
         st_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_write_ff   <= (req_item.req_type == REQ_WRITE);
         st_bad_ff     <= !joint_ok;
         st_joint_ff   <= req_item.joint_index;
         st_phase_ff   <= st_phase_in;
         st_meas_q_ff  <= req_item.meas_q;
         st_meas_dq_ff <= req_item.meas_dq;
      end
   end

   always_comb begin
      push_valid         = st_valid_ff;
      push_job.is_write  = st_write_ff;
      push_job.bad_joint = st_bad_ff;
      push_job.joint     = st_joint_ff;
      push_job.phase     = st_phase_ff;
      push_job.meas_q    = st_meas_q_ff;
      push_job.meas_dq   = st_meas_dq_ff;
      push_job.words     = rd_words;
   end

endmodule

`default_nettype wire

/* sv/jci_queue.sv */
// ----------------------------------------------------------------------------
// jci_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jci_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire jci_pkg::job_type push_job,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output jci_pkg::job_type      pop_job
);
   import jci_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = PW + 1;

   job_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* sv/jci_back.sv */
// ----------------------------------------------------------------------------
// jci_back
// Sequencer that interpolates, clamps and scales one job at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module jci_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_valid,
   output logic                          pop_ready,
   input  wire jci_pkg::job_type         pop_job,
   input  wire jci_pkg::gain_cfg_type    gain_cfg,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output jci_pkg::rsp_payload_type      rsp_item
);
   import jci_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_P1    = 5'd1;
   localparam logic [4:0] ST_P2    = 5'd2;
   localparam logic [4:0] ST_P3    = 5'd3;
   localparam logic [4:0] ST_P4    = 5'd4;
   localparam logic [4:0] ST_P5    = 5'd5;
   localparam logic [4:0] ST_P6    = 5'd6;
   localparam logic [4:0] ST_P7    = 5'd7;
   localparam logic [4:0] ST_TEST  = 5'd8;
   localparam logic [4:0] ST_NORM  = 5'd9;
   localparam logic [4:0] ST_SQ    = 5'd10;
   localparam logic [4:0] ST_LA    = 5'd11;
   localparam logic [4:0] ST_SQRT  = 5'd12;
   localparam logic [4:0] ST_NUM   = 5'd13;
   localparam logic [4:0] ST_DIV   = 5'd14;
   localparam logic [4:0] ST_XSAT  = 5'd15;
   localparam logic [4:0] ST_X2    = 5'd16;
   localparam logic [4:0] ST_X2B   = 5'd17;
   localparam logic [4:0] ST_KPX   = 5'd18;
   localparam logic [4:0] ST_KDX   = 5'd19;
   localparam logic [4:0] ST_CLAMP = 5'd20;
   localparam logic [4:0] ST_OUT   = 5'd21;

   localparam logic signed [33:0] I32_MIN34 = -34'sd2147483648;
   localparam logic signed [33:0] I32_MAX34 = 34'sd2147483647;
   localparam logic signed [33:0] GMAX34    = 34'sd2147483647;
   localparam logic signed [33:0] GMIN34    = -34'sd2147483647;

   function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                  input logic signed [33:0] lo,
                                                  input logic signed [33:0] hi);
      logic signed [33:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
                                                input logic signed [33:0] lo,
                                                input logic signed [33:0] hi);
      logic signed [33:0] r;
      r = clamp34(v, lo, hi);
      return r[31:0];
   endfunction

   function automatic logic signed [47:0] clamp48(input logic signed [47:0] v,
                                                  input logic [30:0] lo,
                                                  input logic [30:0] hi);
      logic signed [47:0] lo_s;
      logic signed [47:0] hi_s;
      logic signed [47:0] r;
      lo_s = signed'({17'b0, lo});
      hi_s = signed'({17'b0, hi});
      if (v < lo_s) begin
         r = lo_s;
      end else if (v > hi_s) begin
         r = hi_s;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] mag_to_s(input logic [63:0] m, input logic neg);
      logic signed [31:0] s;
      s = signed'({1'b0, m[30:0]});
      return neg ? -s : s;
   endfunction

   logic [4:0]          state_ff, state_in;
   job_type             job_ff, job_in;
   logic signed [31:0]  op_a, op_b;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [31:0]  q_ff, q_in, dq_ff, dq_in;
   logic signed [31:0]  eq_ff, eq_in, edq_ff, edq_in;
   logic signed [31:0]  kp_ff, kp_in, kd_ff, kd_in;
   logic signed [63:0]  a_ff, a_in, b_ff, b_in;
   logic                scaled_ff, scaled_in;
   logic                a_neg_ff, a_neg_in, b_neg_ff, b_neg_in, l_neg_ff, l_neg_in;
   logic [63:0]         ma_ff, ma_in, mb_ff, mb_in, ml_ff, ml_in;
   logic signed [63:0]  sq_ff, sq_in;
   logic [63:0]         v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [32:0]         rem_ff, rem_in, dvs_ff, dvs_in;
   logic [48:0]         dvd_ff, dvd_in, quo_ff, quo_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [23:0]         x_ff, x_in;
   logic signed [47:0]  kps_ff, kps_in, kds_ff, kds_in;
   rsp_payload_type     res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_item_ff, rsp_item_in;

   // scratch for the combinational step
   logic signed [31:0]  ph_s;
   logic signed [33:0]  frac34, raw34, dql34, dq34;
   logic signed [63:0]  t_s, lq_s, delta_s;
   logic [63:0]         t_mag, all_mag, rb;
   logic signed [31:0]  ap_s, bp_s, lp_s;
   logic signed [33:0]  sub34, num34;
   logic [33:0]         rs;
   logic                group_upper;
   logic signed [47:0]  kp_c, kd_c;

   always_comb begin
      prod_in = 64'(op_a) * 64'(op_b);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      q_in         = q_ff;
      dq_in        = dq_ff;
      eq_in        = eq_ff;
      edq_in       = edq_ff;
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      scaled_in    = scaled_ff;
      a_neg_in     = a_neg_ff;
      b_neg_in     = b_neg_ff;
      l_neg_in     = l_neg_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      ml_in        = ml_ff;
      sq_in        = sq_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      kps_in       = kps_ff;
      kds_in       = kds_ff;
      res_in       = res_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      pop_ready    = 1'b0;
      op_a         = '0;
      op_b         = '0;

      ph_s    = signed'({15'b0, job_ff.phase});
      frac34  = signed'(prod_ff[49:16]);
      raw34   = '0;
      dql34   = 34'(signed'(job_ff.words[SEL_DQ_LIM]));
      dq34    = '0;
      t_s     = a_ff + b_ff;
      lq_s    = signed'({{16{job_ff.words[SEL_TAU_LIM][31]}}, job_ff.words[SEL_TAU_LIM],
                         16'b0});
      t_mag   = t_s[63] ? 64'(-t_s) : 64'(t_s);
      all_mag = ma_ff | mb_ff | ml_ff;
      ap_s    = mag_to_s(ma_ff, a_neg_ff);
      bp_s    = mag_to_s(mb_ff, b_neg_ff);
      lp_s    = mag_to_s(ml_ff, l_neg_ff);
      delta_s = sq_ff + (prod_ff <<< 2);
      rb      = r_ff + bit_ff;
      sub34   = a_neg_ff ? -34'(bp_s) : 34'(bp_s);
      num34   = signed'({2'b00, r_ff[31:0]}) - sub34;
      rs      = {rem_ff, dvd_ff[48]};
      group_upper = |job_ff.words[SEL_GROUP];
      kp_c    = group_upper ? clamp48(kps_ff, gain_cfg.upper_kp_min, gain_cfg.upper_kp_max)
                            : clamp48(kps_ff, gain_cfg.lower_kp_min, gain_cfg.lower_kp_max);
      kd_c    = group_upper ? clamp48(kds_ff, gain_cfg.upper_kd_min, gain_cfg.upper_kd_max)
                            : clamp48(kds_ff, gain_cfg.lower_kd_min, gain_cfg.lower_kd_max);

      // drop the result once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               job_in    = pop_job;
               res_in    = '0;
               if (pop_job.is_write) begin
                  res_in.write_ack = 1'b1;
                  state_in         = ST_OUT;
               end else if (pop_job.bad_joint) begin
                  res_in.out_joint = pop_job.joint;
                  state_in         = ST_OUT;
               end else begin
                  state_in = ST_P1;
               end
            end
         end
         ST_P1: begin
            op_a     = signed'(job_ff.words[SEL_Q_DELTA]);
            op_b     = ph_s;
            state_in = ST_P2;
         end
         ST_P2: begin
            raw34 = 34'(signed'(job_ff.words[SEL_Q_START])) + frac34;
            q_in  = sat34(clamp34(raw34, 34'(signed'(job_ff.words[SEL_Q_MIN])),
                                  34'(signed'(job_ff.words[SEL_Q_MAX]))),
                          I32_MIN34, I32_MAX34);
            op_a     = signed'(job_ff.words[SEL_DQ_DELTA]);
            op_b     = ph_s;
            state_in = ST_P3;
         end
         ST_P3: begin
            raw34 = 34'(signed'(job_ff.words[SEL_DQ_START])) + frac34;
            dq34  = clamp34(raw34, -dql34, dql34);
            dq_in = sat34(dq34, I32_MIN34, I32_MAX34);
            eq_in = sat34(34'(q_ff) - 34'(job_ff.meas_q), I32_MIN34, I32_MAX34);
            op_a     = signed'(job_ff.words[SEL_KP_DELTA]);
            op_b     = ph_s;
            state_in = ST_P4;
         end
         ST_P4: begin
            raw34  = 34'(signed'(job_ff.words[SEL_KP_START])) + frac34;
            kp_in  = sat34(raw34, GMIN34, GMAX34);
            edq_in = sat34(34'(dq_ff) - 34'(job_ff.meas_dq), I32_MIN34, I32_MAX34);
            op_a     = signed'(job_ff.words[SEL_KD_DELTA]);
            op_b     = ph_s;
            state_in = ST_P5;
         end
         ST_P5: begin
            raw34    = 34'(signed'(job_ff.words[SEL_KD_START])) + frac34;
            kd_in    = sat34(raw34, GMIN34, GMAX34);
            op_a     = kp_ff;
            op_b     = eq_ff;
            state_in = ST_P6;
         end
         ST_P6: begin
            a_in     = prod_ff;
            op_a     = kd_ff;
            op_b     = edq_ff;
            state_in = ST_P7;
         end
         ST_P7: begin
            b_in     = prod_ff;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            scaled_in = lq_s[63] || (t_mag > 64'(lq_s));
            ma_in     = a_ff[63] ? 64'(-a_ff) : 64'(a_ff);
            mb_in     = b_ff[63] ? 64'(-b_ff) : 64'(b_ff);
            ml_in     = lq_s[63] ? 64'(-lq_s) : 64'(lq_s);
            a_neg_in  = a_ff[63];
            b_neg_in  = b_ff[63];
            l_neg_in  = lq_s[63] != (t_s[63] || (t_s == '0));
            kps_in    = 48'(kp_ff);
            kds_in    = 48'(kd_ff);
            if (!(lq_s[63] || (t_mag > 64'(lq_s)))) begin
               state_in = ST_CLAMP;
            end else if (a_ff == '0) begin
               x_in     = '0;
               state_in = ST_X2;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // shift all three terms together until they fit in 30 bits
            if (|all_mag[63:30]) begin
               ma_in = ma_ff >> 1;
               mb_in = mb_ff >> 1;
               ml_in = ml_ff >> 1;
            end else if (ma_ff == '0) begin
               x_in     = '0;
               state_in = ST_X2;
            end else begin
               op_a     = bp_s;
               op_b     = bp_s;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in    = prod_ff;
            op_a     = lp_s;
            op_b     = ap_s;
            state_in = ST_LA;
         end
         ST_LA: begin
            if (delta_s[63]) begin
               x_in     = '0;
               state_in = ST_X2;
            end else begin
               v_in     = 64'(delta_s);
               r_in     = '0;
               bit_in   = 64'(1) << 62;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            if (num34 <= 34'sd0) begin
               x_in     = '0;
               state_in = ST_X2;
            end else begin
               dvd_in   = {num34[32:0], 16'b0};
               dvs_in   = {ma_ff[31:0], 1'b0};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = 6'd48;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rs >= 34'(dvs_ff)) begin
               rem_in = 33'(rs - 34'(dvs_ff));
               quo_in = {quo_ff[47:0], 1'b1};
            end else begin
               rem_in = rs[32:0];
               quo_in = {quo_ff[47:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = ST_XSAT;
            end
         end
         ST_XSAT: begin
            x_in     = (quo_ff > 49'(X_CAP)) ? X_CAP : quo_ff[23:0];
            state_in = ST_X2;
         end
         ST_X2: begin
            op_a     = signed'({8'b0, x_ff});
            op_b     = signed'({8'b0, x_ff});
            state_in = ST_X2B;
         end
         ST_X2B: begin
            op_a     = kp_ff;
            op_b     = signed'(prod_ff[47:16]);
            state_in = ST_KPX;
         end
         ST_KPX: begin
            kps_in   = prod_ff[63:16];
            op_a     = kd_ff;
            op_b     = signed'({8'b0, x_ff});
            state_in = ST_KDX;
         end
         ST_KDX: begin
            kds_in   = prod_ff[63:16];
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            res_in.out_joint     = job_ff.joint;
            res_in.q_cmd         = q_ff;
            res_in.dq_cmd        = dq_ff;
            res_in.kp_cmd        = kp_c[30:0];
            res_in.kd_cmd        = kd_c[30:0];
            res_in.motor_mode    = group_upper;
            res_in.torque_scaled = scaled_ff;
            res_in.write_ack     = 1'b0;
            state_in             = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      prod_ff     <= prod_in;
      q_ff        <= q_in;
      dq_ff       <= dq_in;
      eq_ff       <= eq_in;
      edq_ff      <= edq_in;
      kp_ff       <= kp_in;
      kd_ff       <= kd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      scaled_ff   <= scaled_in;
      a_neg_ff    <= a_neg_in;
      b_neg_ff    <= b_neg_in;
      l_neg_ff    <= l_neg_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      ml_ff       <= ml_in;
      sq_ff       <= sq_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      kps_ff      <= kps_in;
      kds_ff      <= kds_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

/* sv/joint_command_interpolator_core.sv */
// ----------------------------------------------------------------------------
// joint_command_interpolator_core
// Per-joint command interpolation with torque-limited gain scaling.
// ----------------------------------------------------------------------------
// Every item gives one result. A table write item stores one Q16.16 word
// and returns write_ack. A compute item reads all of its joint's words
// together (one small RAM per word) and, when the predicted torque stays
// within the limit, steps through the interpolation states on the single
// shared 32x32 multiplier, used at most once per step. When the gains must
// be scaled the item adds the root unit: a normalizing shift of one bit per
// cycle (up to 32 bits), a 32-step square root and a 49-step divide. The
// front accepts an item every cycle while the two-entry queue has room, so
// items arrive while the back is busy and while a finished result still
// waits on rsp_ready. The table is not cleared by reset: read only words
// that were written. A write to a joint outside NUM_JOINTS or to a word
// select above the group word is dropped but still acknowledged.
// Configuration writes are always ready; issue them only while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_command_interpolator_core #(
   parameter int NUM_JOINTS = jci_pkg::DEFAULT_NUM_JOINTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire jci_pkg::req_payload_type req_item,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output jci_pkg::rsp_payload_type      rsp_item,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [2:0]               csr_index,
   input  wire logic [31:0]              csr_wdata
);
   import jci_pkg::*;

   gain_cfg_type cfg_ff, cfg_in;
   logic         push_valid, push_ready;
   job_type      push_job;
   logic         pop_valid, pop_ready;
   job_type      pop_job;

   // configuration: always ready, one register per write
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOWER_KP_MIN: cfg_in.lower_kp_min = csr_wdata[30:0];
            CSR_LOWER_KP_MAX: cfg_in.lower_kp_max = csr_wdata[30:0];
            CSR_LOWER_KD_MIN: cfg_in.lower_kd_min = csr_wdata[30:0];
            CSR_LOWER_KD_MAX: cfg_in.lower_kd_max = csr_wdata[30:0];
            CSR_UPPER_KP_MIN: cfg_in.upper_kp_min = csr_wdata[30:0];
            CSR_UPPER_KP_MAX: cfg_in.upper_kp_max = csr_wdata[30:0];
            CSR_UPPER_KD_MIN: cfg_in.upper_kd_min = csr_wdata[30:0];
            CSR_UPPER_KD_MAX: cfg_in.upper_kd_max = csr_wdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_kp_min <= '0;
         cfg_ff.lower_kp_max <= GAIN_MAX;
         cfg_ff.lower_kd_min <= '0;
         cfg_ff.lower_kd_max <= GAIN_MAX;
         cfg_ff.upper_kp_min <= '0;
         cfg_ff.upper_kp_max <= GAIN_MAX;
         cfg_ff.upper_kd_min <= '0;
         cfg_ff.upper_kd_max <= GAIN_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept items, store words, fetch a joint's words
   jci_front #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // hold up to two jobs so front and back stall independently
   jci_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // back: interpolate, clamp, scale gains, register the result
   jci_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .gain_cfg  (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

/* sv/jci_checker.sv */
// ----------------------------------------------------------------------------
// jci_checker
// Port-level checks of the joint command interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module jci_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire jci_pkg::req_payload_type req_item,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire jci_pkg::rsp_payload_type rsp_item,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready,
   input wire logic [2:0]               csr_index,
   input wire logic [31:0]              csr_wdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // write acknowledgments carry nothing else
   a_ack_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.write_ack |->
         rsp_item.out_joint == '0 && rsp_item.q_cmd == '0 && rsp_item.dq_cmd == '0 &&
         rsp_item.kp_cmd == '0 && rsp_item.kd_cmd == '0 && !rsp_item.motor_mode &&
         !rsp_item.torque_scaled)
      else $error("write acknowledgment with nonzero fields");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // configuration writes never stall
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind joint_command_interpolator_core jci_checker u_jci_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for joint_command_interpolator_core: table writes and
// compute items go in through valid/ready, a scoreboard class predicts each
// result from its own copy of the joint table and gain bounds, and every
// returned item is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import jci_pkg::*;

   localparam longint I32_LO = -64'sd2147483648;
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint GAIN_HI = 64'sd2147483647;
   localparam int N_JOINTS = 32;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_item;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_item;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   // Predicts one result per item and holds the results still owed.
   class joint_cmd_scoreboard;
      logic [31:0] words[N_JOINTS][16];
      logic [30:0] gain_bound[8];
      rsp_payload_type owed[$];
      int errors;

      function new();
         errors = 0;
         foreach (gain_bound[i]) gain_bound[i] = (i % 2) ? GAIN_MAX : '0;
      endfunction

      function void set_gain(logic [2:0] idx, logic [31:0] val);
         gain_bound[idx] = val[30:0];
      endfunction

      function longint sx(logic [31:0] v);
         return longint'($signed(v));
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function longint lerp(logic [31:0] s, logic [31:0] d, longint ph);
         return sx(s) + ((sx(d) * ph) >>> 16);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // positive root of the torque-limit quadratic, Q16.16
      function longint root_scale(longint a, longint b, longint t, longint lq);
         longint unsigned ma, mb, ml, all_bits, xq;
         int k;
         longint ap, bp, lp, disc, num, den;
         if (a == 0) return 0;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         ml = (lq < 0) ? -lq : lq;
         all_bits = ma | mb | ml;
         k = 0;
         while ((all_bits >> k) >= (64'd1 << 30)) k++;
         ap = longint'(ma >> k);
         bp = longint'(mb >> k);
         lp = longint'(ml >> k);
         if (a < 0) ap = -ap;
         if (b < 0) bp = -bp;
         if ((lq < 0) != (t <= 0)) lp = -lp;
         if (ap == 0) return 0;
         disc = bp * bp + 4 * lp * ap;
         if (disc < 0) return 0;
         num = longint'(int_sqrt(disc)) - ((ap > 0) ? bp : -bp);
         if (num <= 0) return 0;
         den = 2 * ((ap < 0) ? -ap : ap);
         xq = (num <<< 16) / den;
         if (xq > X_CAP) xq = X_CAP;
         return longint'(xq);
      endfunction

      function void note_item(req_payload_type r);
         rsp_payload_type e;
         longint ph, q, dq, kp, kd, dql, eq, edq, a, b, t, lq, x, x2;
         longint unsigned mt;
         logic upper, scaled;
         int base;
         logic [31:0] w[16];
         e = '0;
         if (r.req_type == REQ_WRITE) begin
            if (r.param_select <= SEL_GROUP)
               words[r.joint_index][r.param_select] = r.param_value;
            e.write_ack = 1'b1;
            owed = {owed, e};
            return;
         end
         e.out_joint = r.joint_index;
         w = words[r.joint_index];
         ph = (r.phase > PHASE_ONE) ? 65536 : longint'(r.phase);
         q = lerp(w[SEL_Q_START], w[SEL_Q_DELTA], ph);
         dq = lerp(w[SEL_DQ_START], w[SEL_DQ_DELTA], ph);
         kp = clip(lerp(w[SEL_KP_START], w[SEL_KP_DELTA], ph), -GAIN_HI, GAIN_HI);
         kd = clip(lerp(w[SEL_KD_START], w[SEL_KD_DELTA], ph), -GAIN_HI, GAIN_HI);
         dql = sx(w[SEL_DQ_LIM]);
         upper = (w[SEL_GROUP] != 0);
         q = clip(clip(q, sx(w[SEL_Q_MIN]), sx(w[SEL_Q_MAX])), I32_LO, I32_HI);
         dq = clip(clip(dq, -dql, dql), I32_LO, I32_HI);
         eq = clip(q - sx(r.meas_q), I32_LO, I32_HI);
         edq = clip(dq - sx(r.meas_dq), I32_LO, I32_HI);
         a = kp * eq;
         b = kd * edq;
         t = a + b;
         lq = sx(w[SEL_TAU_LIM]) * 65536;
         mt = (t < 0) ? -t : t;
         scaled = (lq < 0) || (mt > lq);
         if (scaled) begin
            x = root_scale(a, b, t, lq);
            x2 = (x * x) >>> 16;
            kp = (kp * x2) >>> 16;
            kd = (kd * x) >>> 16;
         end
         base = upper ? int'(CSR_UPPER_KP_MIN) : int'(CSR_LOWER_KP_MIN);
         kp = clip(kp, longint'({1'b0, gain_bound[base]}),
                   longint'({1'b0, gain_bound[base + 1]}));
         kd = clip(kd, longint'({1'b0, gain_bound[base + 2]}),
                   longint'({1'b0, gain_bound[base + 3]}));
         e.q_cmd = q[31:0];
         e.dq_cmd = dq[31:0];
         e.kp_cmd = kp[30:0];
         e.kd_cmd = kd[30:0];
         e.motor_mode = upper;
         e.torque_scaled = scaled;
         owed = {owed, e};
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.out_joint !== e.out_joint) mismatch("out_joint", e.out_joint, got.out_joint);
         if (got.q_cmd !== e.q_cmd) mismatch("q_cmd", e.q_cmd, got.q_cmd);
         if (got.dq_cmd !== e.dq_cmd) mismatch("dq_cmd", e.dq_cmd, got.dq_cmd);
         if (got.kp_cmd !== e.kp_cmd) mismatch("kp_cmd", e.kp_cmd, got.kp_cmd);
         if (got.kd_cmd !== e.kd_cmd) mismatch("kd_cmd", e.kd_cmd, got.kd_cmd);
         if (got.motor_mode !== e.motor_mode)
            mismatch("motor_mode", e.motor_mode, got.motor_mode);
         if (got.torque_scaled !== e.torque_scaled)
            mismatch("torque_scaled", e.torque_scaled, got.torque_scaled);
         if (got.write_ack !== e.write_ack) mismatch("write_ack", e.write_ack, got.write_ack);
      endfunction

      function void mismatch(string fld, logic [31:0] exp_v, logic [31:0] act_v);
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, exp_v, act_v);
         errors++;
      endfunction
   endclass

   joint_cmd_scoreboard sb;
   logic [12:0] loaded[N_JOINTS];   // words written per joint
   bit calm;                        // no idling on either side
   int hold_cycles;                 // long receiver hold-off request
   int rsp_gap;

   joint_command_interpolator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: generous bound over the slowest legal run
   initial begin
      #6000000;
      $display("joint_command_interpolator_core verification failed");
      $finish;
   end

   // check every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   // receiver: random short stalls, plus one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      rsp_gap = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            rsp_gap = $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one item and hold it until accepted; returns at a falling edge
   task automatic send_item(req_payload_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_item(r);
      if (r.req_type == REQ_WRITE && r.param_select <= SEL_GROUP)
         loaded[r.joint_index][r.param_select] = 1'b1;
      @(negedge clock);
   endtask

   task automatic table_write(logic [4:0] j, logic [3:0] sel, logic [31:0] v);
      req_payload_type r;
      r = '0;
      r.req_type = REQ_WRITE;
      r.joint_index = j;
      r.param_select = sel;
      r.param_value = v;
      send_item(r);
   endtask

   task automatic compute(logic [4:0] j, logic [16:0] ph, logic [31:0] mq, logic [31:0] mdq);
      req_payload_type r;
      r = '0;
      r.req_type = REQ_COMPUTE;
      r.joint_index = j;
      r.phase = ph;
      r.meas_q = mq;
      r.meas_dq = mdq;
      send_item(r);
   endtask

   // offer one register write; the caller drops csr_valid after the last one
   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_gain(idx, v);
      @(negedge clock);
   endtask

   // wait out every owed result, then the longest root pass
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1: v = ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
         2, 3: v = $urandom;
         default: begin
            v = $urandom_range(0, 32'h000F_FFFF) << $urandom_range(0, 10);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [16:0] pick_phase();
      case ($urandom_range(0, 7))
         0: return PHASE_ONE;
         1: return 17'd0;
         2: return 17'($urandom);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // well-formed traffic: bring a joint's table up, then mostly compute on it
   task automatic random_items(int count);
      logic [4:0] j;
      logic [3:0] sel;
      int k;
      for (k = 0; k < count; k++) begin
         j = $urandom_range(0, N_JOINTS - 1);
         if (loaded[j] != '1) begin
            sel = 0;
            while (loaded[j][sel]) sel++;
            table_write(j, sel, pick_value());
         end else if ($urandom_range(0, 9) < 3) begin
            sel = $urandom_range(0, 15);
            if (sel == SEL_GROUP)
               table_write(j, sel, $urandom_range(0, 1) ? pick_value() : 32'($urandom_range(0, 1)));
            else
               table_write(j, sel, pick_value());
         end else begin
            compute(j, pick_phase(), pick_value(), pick_value());
         end
      end
   endtask

   task automatic gain_set(int mode);
      int i;
      logic [31:0] v;
      for (i = 0; i < 8; i++) begin
         case (mode)
            0: v = (i % 2) ? 32'hFFFF_FFFF : 32'h8000_0000;   // widest, top bit dropped
            1: v = (i % 2) ? $urandom_range(32'h0010_0000, 32'h7FFF_FFFF)
                           : $urandom_range(0, 32'h0004_0000);
            default: v = (i < 4) ? ((i % 2) ? 32'h0 : 32'h7FFF_FFFF) : $urandom;
         endcase
         csr_write(CSR_LOWER_KP_MIN + 3'(i), v);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      foreach (loaded[i]) loaded[i] = '0;
      calm = 1'b0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LOWER_KP_MIN;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      gain_set(0);

      // directed: bring joint 0 up with a tight torque limit so gains scale
      table_write(0, SEL_Q_START, 32'h0001_0000);
      table_write(0, SEL_Q_DELTA, 32'h0002_0000);
      table_write(0, SEL_DQ_START, 32'hFFFF_8000);
      table_write(0, SEL_DQ_DELTA, 32'h0001_0000);
      table_write(0, SEL_KP_START, 32'h0014_0000);
      table_write(0, SEL_KP_DELTA, 32'h7FFF_FFFF);
      table_write(0, SEL_KD_START, 32'h0001_0000);
      table_write(0, SEL_KD_DELTA, 32'h8000_0000);
      table_write(0, SEL_Q_MIN, 32'hFFFF_0000);
      table_write(0, SEL_Q_MAX, 32'h0002_0000);
      table_write(0, SEL_DQ_LIM, 32'h0000_8000);
      table_write(0, SEL_TAU_LIM, 32'h0001_0000);
      table_write(0, SEL_GROUP, 32'h0);
      // dropped writes: word select past the group word
      table_write(5, 4'd13, 32'hDEAD_BEEF);
      table_write(31, 4'd15, 32'h1234_5678);
      compute(0, 17'd0, 32'h0, 32'h0);
      compute(0, PHASE_ONE, 32'h8000_0000, 32'h7FFF_FFFF);
      compute(0, 17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      // negative torque limit always scales
      table_write(0, SEL_TAU_LIM, 32'h8000_0000);
      compute(0, 17'd32768, 32'h0000_1000, 32'hFFFF_0000);
      // widest positive limit, still exceeded here, so gains scale
      table_write(0, SEL_TAU_LIM, 32'h7FFF_FFFF);
      compute(0, 17'd40000, 32'h0, 32'h0);
      // any nonzero group word selects the upper group
      table_write(0, SEL_GROUP, 32'h8000_0000);
      compute(0, 17'd1, 32'h8000_0000, 32'h8000_0000);

      // long receiver hold-off while items keep coming, so the queue fills
      hold_cycles = 400;
      random_items(450);
      drain();
      gain_set(1);
      random_items(450);
      drain();
      gain_set(2);
      random_items(280);
      calm = 1'b1;
      random_items(150);
      drain();

      if (sb.errors == 0)
         $display("joint_command_interpolator_core verification clean");
      else
         $display("joint_command_interpolator_core verification failed");
      $finish;
   end

endmodule
